>>> hdl/owbm_pkg.sv
// Shared types and constants for the single-wire bus master.
`default_nettype none
package owbm_pkg;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_RLOW  = 3'd1,
      PH_RWAIT = 3'd2,
      PH_RTAIL = 3'd3,
      PH_SLOW  = 3'd4,
      PH_SMID  = 3'd5,
      PH_STAIL = 3'd6
   } phase_type;

   localparam logic [1:0] OP_RESET = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [2:0] REG_RESET_LOW     = 3'd0;
   localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
   localparam logic [2:0] REG_RESET_TAIL    = 3'd2;
   localparam logic [2:0] REG_SLOT_LOW      = 3'd3;
   localparam logic [2:0] REG_WRITE_HOLD    = 3'd4;
   localparam logic [2:0] REG_READ_SAMPLE   = 3'd5;
   localparam logic [2:0] REG_READ_TAIL     = 3'd6;
   localparam logic [2:0] REG_WRITE_TAIL    = 3'd7;

   localparam int unsigned TICK_W = 10;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       presence;
   } rsp_type;

endpackage
`default_nettype wire

>>> hdl/one_wire_bus_master.sv
// Single-wire bus master: reset/presence, byte write and byte read, one tick per transfer.
//
// Usage: every transfer on the req_ channel is one timing tick. It carries a
// command request (req_start_req, req_cmd: 0 reset, 1 write, 2 read), the byte
// to write and the sensed bus level. Each accepted tick yields exactly one
// transfer on the rsp_ channel with the bus drive, busy, a one-tick done
// pulse, the receive shift register and the presence flag after that tick.
// Commands are taken only while idle; code three and requests while busy are
// ignored. Tick timings come from eight csr_ registers (the user must write them
// only while idle; the block does not enforce it; csr_ready is always high).
// A tick's result is registered before rsp_ (via the skid register while rsp_stall holds).
// Throughput: one tick per cycle while req_stall is low; the state update of
// a tick is a single counter increment and compare against the selected timing register.
// A two-entry output stage (result register plus skid register) lets the
// block take a tick while a result waits; req_stall rises only when both are
// full and rsp_stall holds the oldest result.
// Reset (synchronous) returns the bus to idle, clears the shift registers and
// presence, loads the default timings and empties the output stage.
`default_nettype none
module one_wire_bus_master (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic       req_start_req,
   input  wire logic [1:0] req_cmd,
   input  wire logic [7:0] req_tx_byte,
   input  wire logic       req_line_level,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic       rsp_drive_low,
   output      logic       rsp_busy_res,
   output      logic       rsp_done_res,
   output      logic [7:0] rsp_rx_byte,
   output      logic       rsp_presence,
   input  wire logic       csr_valid,
   output      logic       csr_ready,
   input  wire logic [2:0] csr_index,
   input  wire logic [9:0] csr_data
);

   localparam int unsigned TW = owbm_pkg::TICK_W;

   // timing registers
   logic [TW-1:0] reset_low_ff, reset_tail_ff;
   logic [7:0]    presence_wait_ff, write_hold_ff, read_sample_ff;
   logic [7:0]    read_tail_ff, write_tail_ff;
   logic [3:0]    slot_low_ff;

   // protocol state
   owbm_pkg::phase_type phase_ff, phase_in;
   logic [TW-1:0] tick_ff, tick_in;
   logic [2:0]    bit_idx_ff, bit_idx_in;
   logic [7:0]    tx_shift_ff, tx_shift_in;
   logic [7:0]    rx_shift_ff, rx_shift_in;
   logic          presence_ff, presence_in;
   logic [1:0]    op_ff, op_in;
   logic          done_in;

   // output stage
   owbm_pkg::rsp_type res, out_ff, skid_ff;
   logic          out_valid_ff, skid_valid_ff;

   logic          accept, take, csr_write;
   logic [TW-1:0] tick_inc, phase_len;
   logic [7:0]    tail_len;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign take      = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff     <= TW'(48);
         presence_wait_ff <= 8'd6;
         reset_tail_ff    <= TW'(41);
         slot_low_ff      <= 4'd1;
         write_hold_ff    <= 8'd6;
         read_sample_ff   <= 8'd2;
         read_tail_ff     <= 8'd1;
         write_tail_ff    <= 8'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            owbm_pkg::REG_RESET_LOW:     reset_low_ff     <= csr_data;
            owbm_pkg::REG_PRESENCE_WAIT: presence_wait_ff <= csr_data[7:0];
            owbm_pkg::REG_RESET_TAIL:    reset_tail_ff    <= csr_data;
            owbm_pkg::REG_SLOT_LOW:      slot_low_ff      <= csr_data[3:0];
            owbm_pkg::REG_WRITE_HOLD:    write_hold_ff    <= csr_data[7:0];
            owbm_pkg::REG_READ_SAMPLE:   read_sample_ff   <= csr_data[7:0];
            owbm_pkg::REG_READ_TAIL:     read_tail_ff     <= csr_data[7:0];
            owbm_pkg::REG_WRITE_TAIL:    write_tail_ff    <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign tick_inc = tick_ff + TW'(1);
   assign tail_len = (op_ff == owbm_pkg::OP_WRITE) ? write_tail_ff : read_tail_ff;

   always_comb begin
      unique case (phase_ff)
         owbm_pkg::PH_RLOW:  phase_len = reset_low_ff;
         owbm_pkg::PH_RWAIT: phase_len = TW'(presence_wait_ff);
         owbm_pkg::PH_RTAIL: phase_len = reset_tail_ff;
         owbm_pkg::PH_SLOW:  phase_len = TW'(slot_low_ff);
         owbm_pkg::PH_SMID:  phase_len = (op_ff == owbm_pkg::OP_WRITE) ?
                                         TW'(write_hold_ff) : TW'(read_sample_ff);
         owbm_pkg::PH_STAIL: phase_len = TW'(tail_len);
         default:            phase_len = TW'(1);
      endcase
   end

   // next state for one tick
   always_comb begin
      phase_in    = phase_ff;
      tick_in     = tick_ff;
      bit_idx_in  = bit_idx_ff;
      tx_shift_in = tx_shift_ff;
      rx_shift_in = rx_shift_ff;
      presence_in = presence_ff;
      op_in       = op_ff;
      done_in     = 1'b0;
      if (phase_ff == owbm_pkg::PH_IDLE) begin
         if (req_start_req && req_cmd <= owbm_pkg::OP_READ) begin
            op_in   = req_cmd;
            tick_in = '0;
            if (req_cmd == owbm_pkg::OP_RESET) begin
               phase_in = owbm_pkg::PH_RLOW;
            end else begin
               bit_idx_in = '0;
               if (req_cmd == owbm_pkg::OP_WRITE) begin
                  tx_shift_in = req_tx_byte;
               end
               phase_in = owbm_pkg::PH_SLOW;
            end
         end
      end else begin
         tick_in = tick_inc;
         if (tick_inc >= phase_len) begin
            tick_in = '0;
            unique case (phase_ff)
               owbm_pkg::PH_RLOW: begin
                  phase_in = owbm_pkg::PH_RWAIT;
               end
               owbm_pkg::PH_RWAIT: begin
                  presence_in = !req_line_level;
                  phase_in    = owbm_pkg::PH_RTAIL;
               end
               owbm_pkg::PH_RTAIL: begin
                  phase_in = owbm_pkg::PH_IDLE;
                  done_in  = 1'b1;
               end
               owbm_pkg::PH_SLOW: begin
                  phase_in = owbm_pkg::PH_SMID;
               end
               owbm_pkg::PH_SMID, owbm_pkg::PH_STAIL: begin
                  if (phase_ff == owbm_pkg::PH_SMID) begin
                     if (op_ff == owbm_pkg::OP_WRITE) begin
                        tx_shift_in = {1'b0, tx_shift_ff[7:1]};
                     end else begin
                        rx_shift_in[bit_idx_ff] = req_line_level;
                     end
                  end
                  if (phase_ff == owbm_pkg::PH_SMID && tail_len != 8'd0) begin
                     phase_in = owbm_pkg::PH_STAIL;
                  end else if (bit_idx_ff == 3'd7) begin
                     phase_in = owbm_pkg::PH_IDLE;
                     done_in  = 1'b1;
                  end else begin
                     bit_idx_in = bit_idx_ff + 3'd1;
                     phase_in   = owbm_pkg::PH_SLOW;
                  end
               end
               default: begin
                  phase_in = owbm_pkg::PH_IDLE;
               end
            endcase
         end
      end
   end

   // result of the tick, from the updated state
   always_comb begin
      res.drive_low = (phase_in == owbm_pkg::PH_RLOW) || (phase_in == owbm_pkg::PH_SLOW) ||
                      (phase_in == owbm_pkg::PH_SMID && op_in == owbm_pkg::OP_WRITE &&
                       !tx_shift_in[0]);
      res.busy_res  = (phase_in != owbm_pkg::PH_IDLE);
      res.done_res  = done_in;
      res.rx_byte   = rx_shift_in;
      res.presence  = presence_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= owbm_pkg::PH_IDLE;
         tick_ff     <= '0;
         bit_idx_ff  <= '0;
         tx_shift_ff <= '0;
         rx_shift_ff <= '0;
         presence_ff <= 1'b0;
         op_ff       <= owbm_pkg::OP_RESET;
      end else if (accept) begin
         phase_ff    <= phase_in;
         tick_ff     <= tick_in;
         bit_idx_ff  <= bit_idx_in;
         tx_shift_ff <= tx_shift_in;
         rx_shift_ff <= rx_shift_in;
         presence_ff <= presence_in;
         op_ff       <= op_in;
      end
   end

   // result register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || take) begin
         out_valid_ff <= accept;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (!out_valid_ff || take) begin
         if (accept) begin
            out_ff <= res;
         end
      end else if (accept) begin
         skid_ff <= res;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_drive_low = out_ff.drive_low;
   assign rsp_busy_res  = out_ff.busy_res;
   assign rsp_done_res  = out_ff.done_res;
   assign rsp_rx_byte   = out_ff.rx_byte;
   assign rsp_presence  = out_ff.presence;

endmodule
`default_nettype wire
